### hw/rtl/cwc_pkg.sv
// shared types and constants for the compact target work check
package cwc_pkg;

   localparam int unsigned HashPartWidth = 64;
   localparam int unsigned CompactWidth  = 32;
   localparam int unsigned MantWidth     = 24;
   localparam int unsigned ExpWidth      = 8;
   localparam int unsigned PartBytes     = HashPartWidth / 8;
   localparam int unsigned PartCount     = 4;
   localparam int unsigned PartIdxWidth  = 2;
   localparam int unsigned RspDataWidth  = 8;

   localparam logic [PartIdxWidth-1:0] LastPart = 2'd3;

   typedef enum logic [1:0] {
      VERDICT_EQUAL   = 2'd0,
      VERDICT_LESS    = 2'd1,
      VERDICT_GREATER = 2'd2
   } verdict_type;

   typedef struct packed {
      logic                     valid;
      logic [HashPartWidth-1:0] limb;
   } target_slice_type;

endpackage

### hw/rtl/cwc_target_slice.sv
// decodes the compact word and picks the 64-bit target slice for one part
module cwc_target_slice
   import cwc_pkg::*;
(
   input  logic [CompactWidth-1:0] compact_bits,
   input  logic [PartIdxWidth-1:0] part_idx,
   output target_slice_type        slice
);

   logic [ExpWidth-1:0]      expo;
   logic [7:0]               m2;
   logic [7:0]               m1;
   logic [7:0]               m0;
   logic                     m2_ok;
   logic                     m1_ok;
   logic                     m0_ok;
   logic                     valid;
   logic [HashPartWidth-1:0] limb;
   logic [8:0]               pos;

   assign expo = compact_bits[CompactWidth-1:MantWidth];
   assign m2   = compact_bits[23:16];
   assign m1   = compact_bits[15:8];
   assign m0   = compact_bits[7:0];

   // a nonzero mantissa byte must land inside the 32 target bytes
   assign m2_ok = (m2 == 8'd0) || ((expo >= 8'd1) && (expo <= 8'd32));
   assign m1_ok = (m1 == 8'd0) || ((expo >= 8'd2) && (expo <= 8'd33));
   assign m0_ok = (m0 == 8'd0) || ((expo >= 8'd3) && (expo <= 8'd34));

   // canonical form: top byte used, or a shifted mantissa with the next byte's msb set
   assign valid = !compact_bits[MantWidth-1] && m2_ok && m1_ok && m0_ok
                  && ((m2 != 8'd0) || m1[7]);

   always_comb begin
      limb = '0;
      pos  = '0;
      for (int j = 0; j < PartBytes; j++) begin
         pos = {4'd0, part_idx, 3'(j)};
         if ({1'b0, expo} == pos + 9'd1) begin
            limb[8*j +: 8] = m2;
         end else if ({1'b0, expo} == pos + 9'd2) begin
            limb[8*j +: 8] = m1;
         end else if ({1'b0, expo} == pos + 9'd3) begin
            limb[8*j +: 8] = m0;
         end
      end
   end

   assign slice.valid = valid;
   assign slice.limb  = valid ? limb : '0;

endmodule

### hw/rtl/compact_target_work_check_top.sv
// top level of the compact target work check
// Takes a 256-bit hash as four 64-bit beats, least significant first, and after
// the fourth beat returns one result beat: whether the hash is at most the target
// described by the compact word in csr_wr_data's register, and whether that word
// is a canonical encoding. One hash beat is accepted every cycle; each beat is
// compared against its target slice in the cycle it is accepted, and the result
// appears in the output register on the cycle after the fourth beat. The output
// register holds one result, so only a fourth beat waits on a full, stalled output.
module compact_target_work_check_top
   import cwc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [HashPartWidth-1:0] req_tdata,   // hash_part
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,   // meets_target, target_valid, zero pad
   input  logic                     csr_wr_en,
   input  logic [CompactWidth-1:0]  csr_wr_data  // compact_bits
);

   logic [CompactWidth-1:0] compact_ff;
   logic [CompactWidth-1:0] compact_in;
   logic [PartIdxWidth-1:0] part_ff;
   logic [PartIdxWidth-1:0] part_in;
   verdict_type             verdict_ff;
   verdict_type             verdict_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    meets_ff;
   logic                    meets_in;
   logic                    tvalid_ff;
   logic                    tvalid_in;

   target_slice_type        slice;
   verdict_type             beat_verdict;
   logic                    accept;
   logic                    last_beat;

   cwc_target_slice u_slice (
      .compact_bits (compact_ff),
      .part_idx     (part_ff),
      .slice        (slice)
   );

   assign last_beat  = (part_ff == LastPart);
   assign req_tready = !last_beat || !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (req_tdata == slice.limb) begin
         beat_verdict = verdict_ff;
      end else if (req_tdata < slice.limb) begin
         beat_verdict = VERDICT_LESS;
      end else begin
         beat_verdict = VERDICT_GREATER;
      end
   end

   always_comb begin
      compact_in   = csr_wr_en ? csr_wr_data : compact_ff;
      part_in      = part_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      meets_in     = meets_ff;
      tvalid_in    = tvalid_ff;
      if (accept) begin
         part_in = part_ff + 2'd1;
         if (last_beat) begin
            verdict_in   = VERDICT_EQUAL;
            rsp_valid_in = 1'b1;
            meets_in     = slice.valid && (beat_verdict != VERDICT_GREATER);
            tvalid_in    = slice.valid;
         end else begin
            verdict_in = beat_verdict;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compact_ff   <= '0;
         part_ff      <= '0;
         verdict_ff   <= VERDICT_EQUAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         compact_ff   <= compact_in;
         part_ff      <= part_in;
         verdict_ff   <= verdict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meets_ff  <= meets_in;
      tvalid_ff <= tvalid_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-2){1'b0}}, tvalid_ff, meets_ff};

endmodule
